// File: rtl/lsnc_pkg.sv
// Package: constants, payload structs and divider control types for the line sensor block
package lsnc_pkg;

    localparam int unsigned NCH              = 8;
    localparam int unsigned SPACING_MM_DEF   = 16;
    localparam int unsigned SMOOTHING_DEF    = 4;
    localparam int unsigned CONFIRM_DEF      = 2;
    localparam int unsigned FULL_SCALE       = 4096;
    localparam int unsigned MIN_DARK_TOTAL   = 50;
    localparam logic [23:0] CALIB_RESET      = 24'hFFF000;
    localparam int unsigned DIV_W            = 32;

    typedef struct packed {
        logic [11:0] raw_ch7;
        logic [11:0] raw_ch6;
        logic [11:0] raw_ch5;
        logic [11:0] raw_ch4;
        logic [11:0] raw_ch3;
        logic [11:0] raw_ch2;
        logic [11:0] raw_ch1;
        logic [11:0] raw_ch0;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  line_mask;
        logic [13:0] line_position;
        logic        position_held;
        logic [12:0] norm_ch0;
        logic [12:0] norm_ch1;
        logic [12:0] norm_ch2;
        logic [12:0] norm_ch3;
        logic [12:0] norm_ch4;
        logic [12:0] norm_ch5;
        logic [12:0] norm_ch6;
        logic [12:0] norm_ch7;
    } out_item_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

// File: rtl/lsnc_divider.sv
// Radix-2 restoring divider, one quotient bit a cycle
module lsnc_divider
    import lsnc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int unsigned CW = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] dvs_reg, dvs_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = CW'(DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next    = DIV_W'(trial - {1'b0, dvs_reg});
                quo_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[DIV_W-1:0];
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider started while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without work");
    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held");

endmodule

// File: rtl/line_sensor_normalize_centroid_unit.sv
// Top level: calibration registers, sequencer and one shared divider
//
//  channel | handshake                   | payload
//  in      | in_valid / in_ready         | in_item (in_item_t)
//  out     | out_valid / out_ready       | out_item (out_item_t)
//  cfg     | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
// A frame runs eight normalising divisions, one per channel, in the shared
// divider, then sums the darkness of the channels and, unless the position is
// held, runs the centroid division; the result register is loaded last.
// Smoothing uses reciprocal multiplies.
// Reset is asynchronous, active low. The block accepts no new frame until the
// result has been taken; the result register holds while out_ready is low.
module line_sensor_normalize_centroid_unit
    import lsnc_pkg::*;
#(
    parameter int unsigned SPACING_MM    = SPACING_MM_DEF,
    parameter int unsigned SMOOTHING     = SMOOTHING_DEF,
    parameter int unsigned CONFIRM_COUNT = CONFIRM_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_item,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [23:0] cfg_data
);

    localparam int unsigned STEP    = SPACING_MM * 100;
    localparam int unsigned MAX_POS = 7 * STEP;
    localparam logic [31:0] CENTRE  = 32'((7 * STEP) / 2);

    // positions stay below 2^16, so a 21-bit shift makes the reciprocal exact
    localparam int unsigned RECIP_SH  = 21;
    localparam int unsigned SMOOTH_DV = (SMOOTHING > 0) ? SMOOTHING : 1;
    localparam logic [21:0] RECIP     = 22'(((1 << RECIP_SH) + SMOOTH_DV - 1) / SMOOTH_DV);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_NSTRT = 3'd1;
    localparam logic [2:0] S_NWAIT = 3'd2;
    localparam logic [2:0] S_ACC   = 3'd3;
    localparam logic [2:0] S_CWAIT = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [23:0]  calib_reg [NCH];
    logic [3:0]   run_reg [NCH];
    logic [3:0]   run_next [NCH];
    logic [7:0]   mask_reg, mask_next;
    logic [31:0]  pos_reg;
    logic [2:0]   state_reg;
    logic [2:0]   ch_reg;
    logic [11:0]  raw_reg [NCH];
    logic [12:0]  norm_reg [NCH];
    logic [31:0]  wsum_reg;
    logic [15:0]  total_reg;
    logic         held_reg;
    logic         out_valid_reg;
    div_req_t     dreq;
    div_rsp_t     drsp;

    // current channel operands
    logic [11:0]  cw, cb, white, black, raw;
    logic [12:0]  mid;
    logic [11:0]  span;
    logic [24:0]  numer;
    logic [12:0]  nval;
    logic [12:0]  dark;
    logic [31:0]  cpos, sm_next;
    logic [37:0]  pos_prod, cpos_prod;

    always_comb
    begin
        cw = calib_reg[ch_reg][23:12];
        cb = calib_reg[ch_reg][11:0];
        raw = raw_reg[ch_reg];
        if (cb >= cw)
        begin
            white = cb;
            black = cw;
        end
        else
        begin
            white = cw;
            black = cb;
        end
        mid   = ({1'b0, white} + {1'b0, black}) >> 1;
        span  = white - black;
        numer = {1'b0, (raw - black), 12'd0};
        nval  = (drsp.quotient > 32'(FULL_SCALE)) ? 13'(FULL_SCALE)
                                                  : drsp.quotient[12:0];
        if (white == black || raw <= black)
            nval = '0;
        dark = 13'(FULL_SCALE) - norm_reg[ch_reg];
        cpos = (drsp.quotient > 32'(MAX_POS)) ? 32'(MAX_POS) : drsp.quotient;
        pos_prod  = pos_reg[15:0] * RECIP;
        cpos_prod = cpos[15:0] * RECIP;
        if (SMOOTHING > 0)
            sm_next = pos_reg - 32'(pos_prod[37:RECIP_SH]) + 32'(cpos_prod[37:RECIP_SH]);
        else
            sm_next = cpos;
    end

    always_comb
    begin
        mask_next = mask_reg;
        for (int i = 0; i < NCH; i++)
            run_next[i] = run_reg[i];
        if (state_reg == S_NSTRT)
        begin
            if ({1'b0, raw} < mid)
            begin
                if (run_reg[ch_reg] < 4'(CONFIRM_COUNT))
                    run_next[ch_reg] = run_reg[ch_reg] + 1'b1;
                if (run_next[ch_reg] >= 4'(CONFIRM_COUNT))
                    mask_next[ch_reg] = 1'b0;
            end
            else
            begin
                run_next[ch_reg]  = '0;
                mask_next[ch_reg] = 1'b1;
            end
        end
    end

    always_comb
    begin
        dreq.start    = 1'b0;
        dreq.dividend = 32'(numer);
        dreq.divisor  = 32'(span);
        if (state_reg == S_NSTRT)
            dreq.start = 1'b1;
        else if (state_reg == S_ACC && ch_reg == 3'd7 && total_reg + 16'(dark) >= 16'(MIN_DARK_TOTAL))
        begin
            dreq.start    = 1'b1;
            dreq.dividend = wsum_reg + 32'(dark) * 32'(7 - 7) * 32'(STEP);
            dreq.divisor  = 32'(total_reg + 16'(dark));
        end
    end

    lsnc_divider u_div (
        .clk (clk),
        .rst_n (rst_n),
        .req (dreq),
        .rsp (drsp)
    );

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign cfg_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ch_reg        <= '0;
            mask_reg      <= 8'hFF;
            pos_reg       <= CENTRE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NCH; i++)
            begin
                calib_reg[i] <= CALIB_RESET;
                run_reg[i]   <= '0;
            end
        end
        else
        begin
            mask_reg <= mask_next;
            for (int i = 0; i < NCH; i++)
                run_reg[i] <= run_next[i];
            if (cfg_valid && cfg_ready)
                calib_reg[cfg_index] <= cfg_data;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && !out_valid_reg)
                    begin
                        ch_reg    <= '0;
                        state_reg <= S_NSTRT;
                    end
                end
                S_NSTRT: state_reg <= S_NWAIT;
                S_NWAIT:
                begin
                    if (drsp.done)
                    begin
                        if (ch_reg == 3'd7)
                        begin
                            ch_reg    <= '0;
                            state_reg <= S_ACC;
                        end
                        else
                        begin
                            ch_reg    <= ch_reg + 1'b1;
                            state_reg <= S_NSTRT;
                        end
                    end
                end
                S_ACC:
                begin
                    if (ch_reg == 3'd7)
                        state_reg <= dreq.start ? S_CWAIT : S_OUT;
                    else
                        ch_reg <= ch_reg + 1'b1;
                end
                S_CWAIT:
                begin
                    if (drsp.done)
                    begin
                        pos_reg   <= sm_next;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid && !out_valid_reg)
        begin
            raw_reg[0] <= in_item.raw_ch0;
            raw_reg[1] <= in_item.raw_ch1;
            raw_reg[2] <= in_item.raw_ch2;
            raw_reg[3] <= in_item.raw_ch3;
            raw_reg[4] <= in_item.raw_ch4;
            raw_reg[5] <= in_item.raw_ch5;
            raw_reg[6] <= in_item.raw_ch6;
            raw_reg[7] <= in_item.raw_ch7;
            wsum_reg   <= '0;
            total_reg  <= '0;
        end
        if (state_reg == S_NWAIT && drsp.done)
            norm_reg[ch_reg] <= nval;
        if (state_reg == S_ACC)
        begin
            wsum_reg  <= wsum_reg + 32'(dark) * 32'(7 - 32'(ch_reg)) * 32'(STEP);
            total_reg <= total_reg + 16'(dark);
            if (ch_reg == 3'd7)
                held_reg <= (total_reg + 16'(dark)) < 16'(MIN_DARK_TOTAL);
        end
        if (state_reg == S_OUT)
        begin
            out_item.line_mask     <= mask_reg;
            out_item.line_position <= pos_reg[13:0];
            out_item.position_held <= held_reg;
            out_item.norm_ch0      <= norm_reg[0];
            out_item.norm_ch1      <= norm_reg[1];
            out_item.norm_ch2      <= norm_reg[2];
            out_item.norm_ch3      <= norm_reg[3];
            out_item.norm_ch4      <= norm_reg[4];
            out_item.norm_ch5      <= norm_reg[5];
            out_item.norm_ch6      <= norm_reg[6];
            out_item.norm_ch7      <= norm_reg[7];
        end
    end

    a_in_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !out_valid_reg) |=> state_reg == S_NSTRT)
        else $error("frame transfer did not start sequencer");
    a_no_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !drsp.busy)
        else $error("config open while dividing");
    a_out_after_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_OUT)
        else $error("result raised outside output state");

endmodule

// File: dv/tb_top.sv
// Testbench for the line sensor normalise and centroid unit, with its own frame predictor
`timescale 1ns / 1ps

module tb_top;
    import lsnc_pkg::*;

    typedef enum logic { ROW_FRAME, ROW_CALIB } row_kind_t;

    typedef struct {
        row_kind_t  kind;
        in_item_t   frame;
        logic [2:0] cal_index;
        logic [23:0] cal_data;
        bit         typed;
        out_item_t  typed_result;
    } stim_row_t;

    localparam int unsigned STEP      = SPACING_MM_DEF * 100;
    localparam int unsigned MAX_POS   = 7 * STEP;
    localparam int unsigned LONG_HOLD = 3000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_item;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_data;

    // predictor state
    logic [23:0] calib_q [NCH];
    int unsigned dark_run_q [NCH];
    logic [7:0]  mask_q;
    int unsigned smooth_pos_q;

    out_item_t   pending_results[$];
    stim_row_t   directed_rows[$];
    int unsigned errors;
    int unsigned frames_taken;
    bit          long_hold_req;
    bit          long_hold_done;

    line_sensor_normalize_centroid_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    initial
    begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [11:0] raw_of(in_item_t x, int i);
        return x[i*12 +: 12];
    endfunction

    function automatic logic [12:0] norm_of(out_item_t o, int i);
        case (i)
            0: return o.norm_ch0;
            1: return o.norm_ch1;
            2: return o.norm_ch2;
            3: return o.norm_ch3;
            4: return o.norm_ch4;
            5: return o.norm_ch5;
            6: return o.norm_ch6;
            default: return o.norm_ch7;
        endcase
    endfunction

    // Advances the sensor state by one frame and returns the result it yields
    function automatic out_item_t centroid_frame(in_item_t x);
        int unsigned       raw, white, black, mid, tmp;
        int unsigned       norm [NCH];
        int unsigned       total;
        longint unsigned   weighted, pos;
        out_item_t         o;
        bit                held;
        total = 0;
        weighted = 0;
        for (int i = 0; i < NCH; i++)
        begin
            raw   = raw_of(x, i);
            white = calib_q[i][23:12];
            black = calib_q[i][11:0];
            if (black >= white)
            begin
                tmp   = white;
                white = black;
                black = tmp;
            end
            mid = (white + black) / 2;
            if (raw < mid)
            begin
                if (dark_run_q[i] < CONFIRM_DEF)
                    dark_run_q[i]++;
                if (dark_run_q[i] >= CONFIRM_DEF)
                    mask_q[i] = 1'b0;
            end
            else
            begin
                dark_run_q[i] = 0;
                mask_q[i] = 1'b1;
            end
            if (white == black || raw <= black)
                norm[i] = 0;
            else
            begin
                norm[i] = ((raw - black) * FULL_SCALE) / (white - black);
                if (norm[i] > FULL_SCALE)
                    norm[i] = FULL_SCALE;
            end
            total    += FULL_SCALE - norm[i];
            weighted += longint'(FULL_SCALE - norm[i]) * (7 - i) * STEP;
        end
        held = total < MIN_DARK_TOTAL;
        if (!held)
        begin
            pos = weighted / total;
            if (pos > MAX_POS)
                pos = MAX_POS;
            if (SMOOTHING_DEF > 0)
                smooth_pos_q = smooth_pos_q - smooth_pos_q / SMOOTHING_DEF
                               + int'(pos) / SMOOTHING_DEF;
            else
                smooth_pos_q = int'(pos);
        end
        o.line_mask     = mask_q;
        o.line_position = smooth_pos_q[13:0];
        o.position_held = held;
        o.norm_ch0 = norm[0][12:0];
        o.norm_ch1 = norm[1][12:0];
        o.norm_ch2 = norm[2][12:0];
        o.norm_ch3 = norm[3][12:0];
        o.norm_ch4 = norm[4][12:0];
        o.norm_ch5 = norm[5][12:0];
        o.norm_ch6 = norm[6][12:0];
        o.norm_ch7 = norm[7][12:0];
        return o;
    endfunction

    // Leaves in_valid high on return so back-to-back transfers need no toggle
    task automatic offer_frame(in_item_t x, bit typed, out_item_t typed_res);
        out_item_t predicted;
        in_valid <= 1'b1;
        in_item  <= x;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = centroid_frame(x);
        pending_results.push_back(typed ? typed_res : predicted);
        frames_taken++;
        if (frames_taken == 400)
            long_hold_req = 1'b1;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_calib(logic [2:0] idx, logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        calib_q[idx] = val;
    endtask

    function automatic logic [23:0] random_calib();
        logic [11:0] a;
        a = 12'($urandom_range(0, 4095));
        case ($urandom_range(0, 9))
            0: return 24'hFFFFFF;
            1: return 24'h000000;
            2: return {a, a};
            3: return {12'($urandom_range(0, 1500)), 12'($urandom_range(2500, 4095))};
            default: return {12'($urandom_range(2500, 4095)), 12'($urandom_range(0, 1500))};
        endcase
    endfunction

    // Line under channels within half_w of ctr, background elsewhere; all_white gives no line
    function automatic in_item_t line_frame(int ctr, int half_w, bit all_white);
        in_item_t    x;
        int unsigned w, b, mid;
        for (int i = 0; i < NCH; i++)
        begin
            w   = calib_q[i][23:12];
            b   = calib_q[i][11:0];
            mid = (w + b) / 2;
            if (!all_white && i >= ctr - half_w && i <= ctr + half_w)
                x[i*12 +: 12] = 12'($urandom_range(0, mid));
            else
                x[i*12 +: 12] = 12'($urandom_range(mid, 4095));
        end
        return x;
    endfunction

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with none expected: %p", $time, out_item);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_item.line_mask !== want.line_mask)
                begin
                    $display("%0t: line_mask expected %h got %h",
                             $time, want.line_mask, out_item.line_mask);
                    errors++;
                end
                if (out_item.line_position !== want.line_position)
                begin
                    $display("%0t: line_position expected %0d got %0d",
                             $time, want.line_position, out_item.line_position);
                    errors++;
                end
                if (out_item.position_held !== want.position_held)
                begin
                    $display("%0t: position_held expected %b got %b",
                             $time, want.position_held, out_item.position_held);
                    errors++;
                end
                for (int i = 0; i < NCH; i++)
                    if (norm_of(out_item, i) !== norm_of(want, i))
                    begin
                        $display("%0t: norm_ch%0d expected %0d got %0d",
                                 $time, i, norm_of(want, i), norm_of(out_item, i));
                        errors++;
                    end
            end
        end
    end

    // Receiver: stall pattern of its own, plus one long hold-off
    initial
    begin
        int run_left;
        int mode;
        run_left = 0;
        mode = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req && !long_hold_done)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_done = 1'b1;
            end
            else
            begin
                if (run_left == 0)
                begin
                    mode = $urandom_range(0, 2);
                    run_left = $urandom_range(5, 400);
                end
                run_left--;
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 3) != 0);
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin
        stim_row_t r;
        out_item_t t_dark, t_white;
        int        burst_left, ctr, half_w, hold_left;
        in_item_t  x;

        in_valid  = 1'b0;
        in_item   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        rst_n     = 1'b0;
        errors = 0;
        frames_taken = 0;
        long_hold_req = 1'b0;
        long_hold_done = 1'b0;
        for (int i = 0; i < NCH; i++)
        begin
            calib_q[i] = CALIB_RESET;
            dark_run_q[i] = 0;
        end
        mask_q = 8'hFF;
        smooth_pos_q = MAX_POS / 2;

        // all-dark frame from reset: centre position, mask not yet confirmed
        t_dark  = '{8'hFF, 14'd5600, 1'b0, 13'd0, 13'd0, 13'd0, 13'd0,
                    13'd0, 13'd0, 13'd0, 13'd0};
        // all-white frame: darkness too low, position held
        t_white = '{8'hFF, 14'd5600, 1'b1, 13'd4096, 13'd4096, 13'd4096, 13'd4096,
                    13'd4096, 13'd4096, 13'd4096, 13'd4096};

        r = '{ROW_FRAME, '0, 3'd0, 24'd0, 1'b1, t_dark};
        directed_rows.push_back(r);
        r.typed = 1'b0;
        directed_rows.push_back(r);
        r = '{ROW_FRAME, {8{12'hFFF}}, 3'd0, 24'd0, 1'b1, t_white};
        directed_rows.push_back(r);
        r.typed = 1'b0;
        r.frame = {{7{12'hFFF}}, 12'h000};
        directed_rows.push_back(r);
        r.frame = {12'h000, {7{12'hFFF}}};
        directed_rows.push_back(r);
        r.frame = {4{24'h555AAA}};
        directed_rows.push_back(r);
        r.frame = {4{24'hAAA555}};
        directed_rows.push_back(r);
        r.kind = ROW_CALIB;
        r.cal_index = 3'd0; r.cal_data = 24'hBB83E8; directed_rows.push_back(r);
        r.cal_index = 3'd1; r.cal_data = 24'h3E8BB8; directed_rows.push_back(r); // swapped
        r.cal_index = 3'd2; r.cal_data = 24'h7D07D0; directed_rows.push_back(r); // equal
        r.cal_index = 3'd3; r.cal_data = 24'h000000; directed_rows.push_back(r);
        r.cal_index = 3'd4; r.cal_data = 24'hFFFFFF; directed_rows.push_back(r);
        r.cal_index = 3'd5; r.cal_data = 24'hC00100; directed_rows.push_back(r);
        r.cal_index = 3'd6; r.cal_data = 24'h001FFF; directed_rows.push_back(r);
        r.cal_index = 3'd7; r.cal_data = 24'h800400; directed_rows.push_back(r);
        r.kind = ROW_FRAME;
        r.frame = '0;                        directed_rows.push_back(r); // at/below black
        r.frame = {8{12'hFFF}};              directed_rows.push_back(r); // at/above white
        r.frame = {8{12'h7D0}};              directed_rows.push_back(r);
        r.frame = {8{12'h3E9}};              directed_rows.push_back(r);
        r.frame = {8{12'hBB8}};              directed_rows.push_back(r);
        r.frame = {12'h000, {6{12'hFFF}}, 12'h000}; directed_rows.push_back(r);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
        begin
            if (directed_rows[k].kind == ROW_CALIB)
            begin
                if (k == 0 || directed_rows[k-1].kind != ROW_CALIB)
                    wait_idle();
                write_calib(directed_rows[k].cal_index, directed_rows[k].cal_data);
                if (k + 1 >= directed_rows.size() || directed_rows[k+1].kind != ROW_CALIB)
                    cfg_valid <= 1'b0;
            end
            else
                offer_frame(directed_rows[k].frame, directed_rows[k].typed,
                            directed_rows[k].typed_result);
        end

        ctr = 3;
        half_w = 0;
        hold_left = 0;
        for (int ph = 0; ph < 6; ph++)
        begin
            wait_idle();
            for (int i = 0; i < NCH; i++)
                write_calib(3'(i), ph == 5 ? CALIB_RESET : random_calib());
            cfg_valid <= 1'b0;
            burst_left = $urandom_range(1, 12);
            for (int n = 0; n < 150; n++)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    if (hold_left == 0)
                    begin
                        hold_left = $urandom_range(1, 5);
                        ctr = $urandom_range(0, 7);
                        half_w = $urandom_range(0, 1);
                    end
                    hold_left--;
                    x = line_frame(ctr, half_w, $urandom_range(0, 9) == 0);
                end
                else
                    x = {$urandom, $urandom, $urandom};
                offer_frame(x, 1'b0, '0);
                burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 12);
                    if ($urandom_range(0, 2) != 0)
                    begin
                        in_valid <= 1'b0;
                        repeat ($urandom_range(1, 20)) @(posedge clk);
                    end
                end
            end
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/lsnc_pkg.sv
rtl/lsnc_divider.sv
rtl/line_sensor_normalize_centroid_unit.sv
dv/tb_top.sv
